// ===== rtl/core/atan_pkg.sv =====
// Shared types and constants for the arctangent series block.
// Holds the FPU operation codes, the request and response structs, and the
// double-precision constants. No dependencies.
package atan_pkg;

    // Operations of the shared floating-point unit
    typedef enum logic [1:0] {
        FOP_ADD = 2'd0,
        FOP_SUB = 2'd1,
        FOP_MUL = 2'd2,
        FOP_DIV = 2'd3
    } t_fpu_op;

    typedef struct packed {
        logic        start;
        t_fpu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_fpu_rsp;

    // IEEE 754 double bit patterns
    localparam logic [63:0] C_ONE        = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] C_TWO        = 64'h4000_0000_0000_0000;
    localparam logic [63:0] C_THREE      = 64'h4008_0000_0000_0000;
    localparam logic [63:0] C_TEN        = 64'h4024_0000_0000_0000;
    localparam logic [63:0] C_SQRT3      = 64'h3FFB_B67A_E858_4CAA;
    localparam logic [63:0] C_TWO_M_SQ3  = 64'h3FD1_2614_5E9E_CD58;
    localparam logic [63:0] C_HALF_PI    = 64'h3FF9_21FB_5444_2D18;
    localparam logic [63:0] C_SIXTH_PI   = 64'h3FE0_C152_382D_7366;
    localparam logic [63:0] C_BIG_LIMIT  = 64'h7FE1_CCF3_85EB_C8A0;
    localparam logic [63:0] C_TINY_LIMIT = 64'h0007_30D6_7819_E8D2;
    localparam logic [63:0] C_QNAN       = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] C_PINF       = 64'h7FF0_0000_0000_0000;

    // Powers of ten as doubles, 1e0 to 1e15
    function automatic logic [63:0] ten_pow(input logic [3:0] k);
        logic [63:0] v;
        case (k)
            4'd0:    v = 64'h3FF0_0000_0000_0000;
            4'd1:    v = 64'h4024_0000_0000_0000;
            4'd2:    v = 64'h4059_0000_0000_0000;
            4'd3:    v = 64'h408F_4000_0000_0000;
            4'd4:    v = 64'h40C3_8800_0000_0000;
            4'd5:    v = 64'h40F8_6A00_0000_0000;
            4'd6:    v = 64'h412E_8480_0000_0000;
            4'd7:    v = 64'h4163_12D0_0000_0000;
            4'd8:    v = 64'h4197_D784_0000_0000;
            4'd9:    v = 64'h41CD_CD65_0000_0000;
            4'd10:   v = 64'h4202_A05F_2000_0000;
            4'd11:   v = 64'h4237_4876_E800_0000;
            4'd12:   v = 64'h426D_1A94_A200_0000;
            4'd13:   v = 64'h42A2_309C_E540_0000;
            4'd14:   v = 64'h42D6_BCC4_1E90_0000;
            default: v = 64'h430C_6BF5_2634_0000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/atan_fpu.sv =====
// Iterative double-precision unit: add, subtract, multiply, divide with
// round to nearest even and subnormal support. Depends on atan_pkg.
module atan_fpu import atan_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_fpu_req i_req,
    output t_fpu_rsp o_rsp
);

    typedef enum logic [9:0] {
        F_IDLE = 10'b00_0000_0001,
        F_NRMA = 10'b00_0000_0010,
        F_NRMB = 10'b00_0000_0100,
        F_ALGN = 10'b00_0000_1000,
        F_ADD  = 10'b00_0001_0000,
        F_MUL  = 10'b00_0010_0000,
        F_DIV  = 10'b00_0100_0000,
        F_NORM = 10'b00_1000_0000,
        F_SUBN = 10'b01_0000_0000,
        F_RND  = 10'b10_0000_0000
    } t_fstate;

    t_fstate            r_state, n_state;
    t_fpu_op            r_op, n_op;
    logic               r_sa, n_sa, r_sb, n_sb, r_s, n_s;
    logic signed [13:0] r_ea, n_ea, r_eb, n_eb, r_e, n_e;
    logic [52:0]        r_ma, n_ma, r_mb, n_mb, r_lo, n_lo;
    logic [56:0]        r_x, n_x, r_y, n_y;
    logic [6:0]         r_cnt, n_cnt;
    logic [63:0]        r_res, n_res;
    logic               r_done, n_done;

    logic [10:0]        a_exp, b_exp;
    logic               a_zero, b_zero, a_big;
    logic signed [13:0] e_diff;
    logic [53:0]        mul_sum, div_rem, div_dif;
    logic               div_ge;
    logic               rnd_up;
    logic [53:0]        rnd_sum;
    logic [52:0]        rnd_mant;
    logic signed [13:0] rnd_e;

    assign a_exp  = i_req.a[62:52];
    assign b_exp  = i_req.b[62:52];
    assign a_zero = (i_req.a[62:0] == 63'd0);
    assign b_zero = (i_req.b[62:0] == 63'd0);

    // Working values for alignment, multiply, divide and rounding
    always_comb begin
        a_big    = (r_ea > r_eb) || ((r_ea == r_eb) && (r_ma >= r_mb));
        e_diff   = a_big ? (r_ea - r_eb) : (r_eb - r_ea);
        mul_sum  = {1'b0, r_x[52:0]} + (r_lo[0] ? {1'b0, r_ma} : 54'd0);
        div_rem  = r_x[53:0];
        div_ge   = (div_rem >= {1'b0, r_mb});
        div_dif  = div_ge ? (div_rem - {1'b0, r_mb}) : div_rem;
        rnd_up   = r_x[2] & (r_x[1] | r_x[0] | r_x[3]);
        rnd_sum  = {1'b0, r_x[55:3]} + {53'd0, rnd_up};
        rnd_mant = rnd_sum[53] ? rnd_sum[53:1] : rnd_sum[52:0];
        rnd_e    = rnd_sum[53] ? (r_e + 14'sd1) : r_e;
    end

    // Sequence one operation
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_s     = r_s;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_e     = r_e;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_lo    = r_lo;
        n_x     = r_x;
        n_y     = r_y;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_done  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_sa  = i_req.a[63];
                    n_sb  = (i_req.op == FOP_SUB) ? ~i_req.b[63] : i_req.b[63];
                    n_ea  = (a_exp == 11'd0) ? 14'sd1 : $signed({3'b000, a_exp});
                    n_eb  = (b_exp == 11'd0) ? 14'sd1 : $signed({3'b000, b_exp});
                    n_ma  = {a_exp != 11'd0, i_req.a[51:0]};
                    n_mb  = {b_exp != 11'd0, i_req.b[51:0]};
                    n_state = F_NRMA;
                    case (i_req.op)
                        FOP_MUL: begin
                            if (a_zero || b_zero) begin
                                n_res   = {i_req.a[63] ^ i_req.b[63], 63'd0};
                                n_done  = 1'b1;
                                n_state = F_IDLE;
                            end
                        end
                        FOP_DIV: begin
                            if (a_zero) begin
                                n_res   = {i_req.a[63] ^ i_req.b[63], 63'd0};
                                n_done  = 1'b1;
                                n_state = F_IDLE;
                            end
                        end
                        default: begin
                            if (a_zero && b_zero) begin
                                n_res   = {n_sa & n_sb, 63'd0};
                                n_done  = 1'b1;
                                n_state = F_IDLE;
                            end else if (a_zero) begin
                                n_res   = {n_sb, i_req.b[62:0]};
                                n_done  = 1'b1;
                                n_state = F_IDLE;
                            end else if (b_zero) begin
                                n_res   = i_req.a;
                                n_done  = 1'b1;
                                n_state = F_IDLE;
                            end
                        end
                    endcase
                end
            end
            // Normalise subnormal operands one bit a cycle
            F_NRMA: begin
                if (r_ma[52]) begin
                    n_state = F_NRMB;
                end else begin
                    n_ma = {r_ma[51:0], 1'b0};
                    n_ea = r_ea - 14'sd1;
                end
            end
            F_NRMB: begin
                if (!r_mb[52]) begin
                    n_mb = {r_mb[51:0], 1'b0};
                    n_eb = r_eb - 14'sd1;
                end else begin
                    case (r_op)
                        FOP_MUL: begin
                            n_x     = 57'd0;
                            n_lo    = r_mb;
                            n_e     = r_ea + r_eb - 14'sd1023;
                            n_s     = r_sa ^ r_sb;
                            n_cnt   = 7'd53;
                            n_state = F_MUL;
                        end
                        FOP_DIV: begin
                            n_x     = {4'd0, r_ma};
                            n_y     = 57'd0;
                            n_e     = r_ea - r_eb + 14'sd1023;
                            n_s     = r_sa ^ r_sb;
                            n_cnt   = 7'd57;
                            n_state = F_DIV;
                        end
                        default: begin
                            n_x     = {1'b0, a_big ? r_ma : r_mb, 3'b000};
                            n_y     = {1'b0, a_big ? r_mb : r_ma, 3'b000};
                            n_e     = a_big ? r_ea : r_eb;
                            n_s     = a_big ? r_sa : r_sb;
                            n_cnt   = (e_diff > 14'sd58) ? 7'd58 : e_diff[6:0];
                            n_state = F_ALGN;
                        end
                    endcase
                end
            end
            // Shift the smaller addend right, folding lost bits into sticky
            F_ALGN: begin
                if (r_cnt != 7'd0) begin
                    n_y   = {1'b0, r_y[56:2], r_y[1] | r_y[0]};
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    n_state = F_ADD;
                end
            end
            F_ADD: begin
                n_x     = (r_sa ^ r_sb) ? (r_x - r_y) : (r_x + r_y);
                n_state = F_NORM;
            end
            // Shift-and-add multiply, one multiplier bit a cycle
            F_MUL: begin
                if (r_cnt != 7'd0) begin
                    n_x   = {4'd0, mul_sum[53:1]};
                    n_lo  = {mul_sum[0], r_lo[52:1]};
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    n_x     = {r_x[52:0], r_lo[52:50], |r_lo[49:0]};
                    n_state = F_NORM;
                end
            end
            // Restoring divide, one quotient bit a cycle
            F_DIV: begin
                if (r_cnt != 7'd0) begin
                    n_x   = {3'd0, div_dif[52:0], 1'b0};
                    n_y   = {r_y[55:0], div_ge};
                    n_cnt = r_cnt - 7'd1;
                end else begin
                    n_x     = {1'b0, r_y[56:2], r_y[1] | r_y[0] | (div_rem != 54'd0)};
                    n_state = F_NORM;
                end
            end
            F_NORM: begin
                if (r_x == 57'd0) begin
                    n_res   = 64'd0;
                    n_done  = 1'b1;
                    n_state = F_IDLE;
                end else if (r_x[56]) begin
                    n_x = {1'b0, r_x[56:2], r_x[1] | r_x[0]};
                    n_e = r_e + 14'sd1;
                end else if (!r_x[55]) begin
                    n_x = {r_x[55:0], 1'b0};
                    n_e = r_e - 14'sd1;
                end else begin
                    n_state = F_SUBN;
                end
            end
            // Denormalise results below the normal range
            F_SUBN: begin
                if (r_e < 14'sd1) begin
                    if (r_e < -14'sd57) begin
                        n_x = {56'd0, |r_x};
                        n_e = 14'sd1;
                    end else begin
                        n_x = {1'b0, r_x[56:2], r_x[1] | r_x[0]};
                        n_e = r_e + 14'sd1;
                    end
                end else begin
                    n_state = F_RND;
                end
            end
            F_RND: begin
                if (rnd_e >= 14'sd2047) begin
                    n_res = {r_s, 11'h7FF, 52'd0};
                end else begin
                    n_res = {r_s, rnd_mant[52] ? rnd_e[10:0] : 11'd0, rnd_mant[51:0]};
                end
                n_done  = 1'b1;
                n_state = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op  <= n_op;
        r_sa  <= n_sa;
        r_sb  <= n_sb;
        r_s   <= n_s;
        r_ea  <= n_ea;
        r_eb  <= n_eb;
        r_e   <= n_e;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_lo  <= n_lo;
        r_x   <= n_x;
        r_y   <= n_y;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

// ===== rtl/core/arctangent_series.sv =====
// Arctangent of an IEEE 754 double by an alternating Taylor series.
// Sequencer around one shared iterative FPU. Depends on atan_pkg, atan_fpu.
//
// Usage:
//   Input: drive i_arg_bits and raise i_start; the item is taken at a clock
//   edge where i_start is high and o_busy is low. o_busy stays high while
//   the item is worked on.
//   Output: o_result_bits is valid for exactly one cycle while o_done is
//   high. The receiver cannot stall; it must take the result in that cycle.
//   Config: i_digits_we writes i_digits (significant digits, 0 acts as 1).
//   Write it only while the block is idle.
//   Flow: NaN, zero and out-of-range inputs are answered straight from idle.
//   Otherwise every arithmetic step runs on the shared FPU, which works a
//   multiply or divide one bit per cycle. Each series term costs a multiply,
//   a divide and two adds, plus the convergence test, which scales both sums
//   by tens (one FPU multiply or divide per decade, roughly 2*d per term for
//   d digits). The next item waits for o_done.
//   Reset: synchronous, active low; returns to idle with digits = 8.
module arctangent_series import atan_pkg::*; #(
    parameter int P_MAX_TERMS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_arg_bits,
    output logic        o_done,
    output logic [63:0] o_result_bits,
    input  logic        i_digits_we,
    input  logic [3:0]  i_digits
);

    localparam int NW = $clog2(P_MAX_TERMS + 1);

    typedef enum logic [20:0] {
        ST_IDLE  = 21'h000001,
        ST_RECIP = 21'h000002,
        ST_RED   = 21'h000004,
        ST_SHMUL = 21'h000008,
        ST_SHSUB = 21'h000010,
        ST_SHADD = 21'h000020,
        ST_SHDIV = 21'h000040,
        ST_SINIT = 21'h000080,
        ST_SQ    = 21'h000100,
        ST_TMUL  = 21'h000200,
        ST_TDIV  = 21'h000400,
        ST_YADD  = 21'h000800,
        ST_DEN   = 21'h001000,
        ST_CHK   = 21'h002000,
        ST_SCDN  = 21'h004000,
        ST_SCUP  = 21'h008000,
        ST_SCEND = 21'h010000,
        ST_PSH   = 21'h020000,
        ST_PRC   = 21'h040000,
        ST_FIN   = 21'h080000
    } t_state;

    t_state          r_state, n_state;
    logic            r_pend, n_pend;
    logic [63:0]     r_x, n_x, r_y, n_y, r_term, n_term, r_sq, n_sq;
    logic [63:0]     r_prev, n_prev, r_den, n_den, r_sc, n_sc, r_t1, n_t1;
    logic [49:0]     r_ss, n_ss;
    logic            r_neg, n_neg, r_recip, n_recip, r_shift, n_shift;
    logic            r_second, n_second;
    logic [NW-1:0]   r_n, n_n;
    logic [3:0]      r_digits;
    logic [63:0]     r_res, n_res;
    logic            r_done, n_done;

    t_fpu_req        fpu_req;
    t_fpu_rsp        fpu_rsp;
    logic [3:0]      d_eff;
    logic [63:0]     lim_hi, lim_lo, arg_abs;
    logic            arg_nan, more_terms;

    // Integer part of a double in [1, 2^50)
    function automatic logic [49:0] int_part(input logic [63:0] v);
        logic [5:0]  sh;
        logic [52:0] m;
        sh = 6'(11'd1075 - v[62:52]);
        m  = {1'b1, v[51:0]} >> sh;
        return m[49:0];
    endfunction

    atan_fpu u_fpu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (fpu_req),
        .o_rsp  (fpu_rsp)
    );

    assign d_eff      = (r_digits == 4'd0) ? 4'd1 : r_digits;
    assign lim_hi     = ten_pow(d_eff);
    assign lim_lo     = ten_pow(d_eff - 4'd1);
    assign arg_abs    = {1'b0, i_arg_bits[62:0]};
    assign arg_nan    = (i_arg_bits[62:52] == 11'h7FF) && (i_arg_bits[51:0] != 52'd0);
    assign more_terms = (r_n < NW'(P_MAX_TERMS));

    // Sequencer: each arithmetic state issues one FPU operation and waits
    always_comb begin
        n_state  = r_state;
        n_pend   = r_pend;
        n_x      = r_x;
        n_y      = r_y;
        n_term   = r_term;
        n_sq     = r_sq;
        n_prev   = r_prev;
        n_den    = r_den;
        n_sc     = r_sc;
        n_t1     = r_t1;
        n_ss     = r_ss;
        n_neg    = r_neg;
        n_recip  = r_recip;
        n_shift  = r_shift;
        n_second = r_second;
        n_n      = r_n;
        n_res    = r_res;
        n_done   = 1'b0;
        fpu_req.start = 1'b0;
        fpu_req.op    = FOP_ADD;
        fpu_req.a     = r_x;
        fpu_req.b     = r_y;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (arg_nan) begin
                        n_res  = C_QNAN;
                        n_done = 1'b1;
                    end else if (arg_abs == 64'd0) begin
                        n_res  = 64'd0;
                        n_done = 1'b1;
                    end else if (arg_abs > C_BIG_LIMIT || arg_abs < C_TINY_LIMIT) begin
                        n_res  = C_PINF;
                        n_done = 1'b1;
                    end else begin
                        n_neg   = i_arg_bits[63];
                        n_recip = (arg_abs > C_ONE);
                        n_x     = arg_abs;
                        n_state = (arg_abs > C_ONE) ? ST_RECIP : ST_RED;
                    end
                end
            end
            ST_RECIP: begin
                fpu_req.start = !r_pend;
                fpu_req.op    = FOP_DIV;
                fpu_req.a     = C_ONE;
                fpu_req.b     = r_x;
                if (fpu_rsp.done) begin
                    n_x     = fpu_rsp.result;
                    n_state = ST_RED;
                end
            end
            ST_RED: begin
                n_shift = (r_x > C_TWO_M_SQ3);
                n_state = (r_x > C_TWO_M_SQ3) ? ST_SHMUL : ST_SINIT;
            end
            // Reduce by the pi/6 identity
            ST_SHMUL: begin
                fpu_req.start = !r_pend;
                fpu_req.op    = FOP_MUL;
                fpu_req.a     = C_SQRT3;
                fpu_req.b     = r_x;
                if (fpu_rsp.done) begin
                    n_t1    = fpu_rsp.result;
                    n_state = ST_SHSUB;
                end
            end
            ST_SHSUB: begin
                fpu_req.start = !r_pend;
                fpu_req.op    = FOP_SUB;
                fpu_req.a     = r_t1;
                fpu_req.b     = C_ONE;
                if (fpu_rsp.done) begin
                    n_t1    = fpu_rsp.result;
                    n_state = ST_SHADD;
                end
            end
            ST_SHADD: begin
                fpu_req.start = !r_pend;
                fpu_req.op    = FOP_ADD;
                fpu_req.a     = C_SQRT3;
                fpu_req.b     = r_x;
                if (fpu_rsp.done) begin
                    n_term  = fpu_rsp.result;
                    n_state = ST_SHDIV;
                end
            end
            ST_SHDIV: begin
                fpu_req.start = !r_pend;
                fpu_req.op    = FOP_DIV;
                fpu_req.a     = r_t1;
                fpu_req.b     = r_term;
                if (fpu_rsp.done) begin
                    n_x     = fpu_rsp.result;
                    n_state = ST_SINIT;
                end
            end
            ST_SINIT: begin
                n_y = r_x;
                if (r_x[62:0] == 63'd0) begin
                    n_state = ST_PSH;
                end else begin
                    n_term  = r_x;
                    n_den   = C_THREE;
                    n_n     = '0;
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                fpu_req.start = !r_pend;
                fpu_req.op    = FOP_MUL;
                fpu_req.a     = r_x;
                fpu_req.b     = r_x;
                if (fpu_rsp.done) begin
                    n_sq    = fpu_rsp.result;
                    n_state = ST_TMUL;
                end
            end
            // One series term: negate term*x^2, divide by odd denominator, add
            ST_TMUL: begin
                fpu_req.start = !r_pend;
                fpu_req.op    = FOP_MUL;
                fpu_req.a     = r_term;
                fpu_req.b     = r_sq;
                if (fpu_rsp.done) begin
                    n_term  = {~fpu_rsp.result[63], fpu_rsp.result[62:0]};
                    n_prev  = r_y;
                    n_state = ST_TDIV;
                end
            end
            ST_TDIV: begin
                fpu_req.start = !r_pend;
                fpu_req.op    = FOP_DIV;
                fpu_req.a     = r_term;
                fpu_req.b     = r_den;
                if (fpu_rsp.done) begin
                    n_t1    = fpu_rsp.result;
                    n_state = ST_YADD;
                end
            end
            ST_YADD: begin
                fpu_req.start = !r_pend;
                fpu_req.op    = FOP_ADD;
                fpu_req.a     = r_y;
                fpu_req.b     = r_t1;
                if (fpu_rsp.done) begin
                    n_y     = fpu_rsp.result;
                    n_state = ST_DEN;
                end
            end
            ST_DEN: begin
                fpu_req.start = !r_pend;
                fpu_req.op    = FOP_ADD;
                fpu_req.a     = r_den;
                fpu_req.b     = C_TWO;
                if (fpu_rsp.done) begin
                    n_den   = fpu_rsp.result;
                    n_n     = r_n + NW'(1);
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (r_y[62:0] == 63'd0 || r_prev[62:0] == 63'd0) begin
                    n_state = more_terms ? ST_TMUL : ST_PSH;
                end else begin
                    n_sc     = {1'b0, r_y[62:0]};
                    n_second = 1'b0;
                    n_state  = ST_SCDN;
                end
            end
            // Scale down by tens while above the upper limit
            ST_SCDN: begin
                fpu_req.start = !r_pend && (r_sc > lim_hi);
                fpu_req.op    = FOP_DIV;
                fpu_req.a     = r_sc;
                fpu_req.b     = C_TEN;
                if (fpu_rsp.done) begin
                    n_sc = fpu_rsp.result;
                end else if (!r_pend && !(r_sc > lim_hi)) begin
                    n_state = ST_SCUP;
                end
            end
            // Scale up by tens while below the lower limit
            ST_SCUP: begin
                fpu_req.start = !r_pend && (r_sc < lim_lo);
                fpu_req.op    = FOP_MUL;
                fpu_req.a     = r_sc;
                fpu_req.b     = C_TEN;
                if (fpu_rsp.done) begin
                    n_sc = fpu_rsp.result;
                end else if (!r_pend && !(r_sc < lim_lo)) begin
                    n_state = ST_SCEND;
                end
            end
            ST_SCEND: begin
                if (!r_second) begin
                    n_ss     = int_part(r_sc);
                    n_sc     = {1'b0, r_prev[62:0]};
                    n_second = 1'b1;
                    n_state  = ST_SCDN;
                end else if (int_part(r_sc) == r_ss || !more_terms) begin
                    n_state = ST_PSH;
                end else begin
                    n_state = ST_TMUL;
                end
            end
            // Undo the reductions
            ST_PSH: begin
                fpu_req.start = !r_pend && r_shift;
                fpu_req.op    = FOP_ADD;
                fpu_req.a     = r_y;
                fpu_req.b     = C_SIXTH_PI;
                if (fpu_rsp.done) begin
                    n_y     = fpu_rsp.result;
                    n_state = ST_PRC;
                end else if (!r_pend && !r_shift) begin
                    n_state = ST_PRC;
                end
            end
            ST_PRC: begin
                fpu_req.start = !r_pend && r_recip;
                fpu_req.op    = FOP_SUB;
                fpu_req.a     = C_HALF_PI;
                fpu_req.b     = r_y;
                if (fpu_rsp.done) begin
                    n_y     = fpu_rsp.result;
                    n_state = ST_FIN;
                end else if (!r_pend && !r_recip) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_res   = {r_y[63] ^ r_neg, r_y[62:0]};
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (fpu_req.start) begin
            n_pend = 1'b1;
        end
        if (fpu_rsp.done) begin
            n_pend = 1'b0;
        end
    end

    // Hold control state, the datapath registers and the digits register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
            r_digits <= 4'd8;
            r_n      <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_done  <= n_done;
            r_n     <= n_n;
            if (i_digits_we) begin
                r_digits <= i_digits;
            end
        end
        r_x      <= n_x;
        r_y      <= n_y;
        r_term   <= n_term;
        r_sq     <= n_sq;
        r_prev   <= n_prev;
        r_den    <= n_den;
        r_sc     <= n_sc;
        r_t1     <= n_t1;
        r_ss     <= n_ss;
        r_neg    <= n_neg;
        r_recip  <= n_recip;
        r_shift  <= n_shift;
        r_second <= n_second;
        r_res    <= n_res;
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_result_bits = r_res;

    // A result is only shown once the sequencer is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    // The FPU only answers an operation that was issued
    a_rsp_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_rsp.done |-> r_pend)
        else $error("FPU response without request");

    // An accepted item either finishes at once or keeps the block busy
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted item dropped");

    // Term count never passes its bound
    a_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(P_MAX_TERMS))
        else $error("term count overrun");

endmodule

// ===== bench/arctangent_series_test.sv =====
// Testbench for arctangent_series: drives IEEE double arguments, predicts each
// arctangent with real arithmetic and checks every result bit for bit.
// Depends on atan_pkg and arctangent_series.
`timescale 1ns / 100ps

module arctangent_series_test;
    import atan_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [63:0] i_arg_bits;
    logic        o_done;
    logic [63:0] o_result_bits;
    logic        i_digits_we;
    logic [3:0]  i_digits;

    logic [63:0] atan_queue[$];
    logic [3:0]  digits_shadow;
    int          error_count;
    int          idle_cycles;

    arctangent_series uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_arg_bits    (i_arg_bits),
        .o_done        (o_done),
        .o_result_bits (o_result_bits),
        .i_digits_we   (i_digits_we),
        .i_digits      (i_digits)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Both partial sums scaled by tens into one decade, then integer parts compared
    function automatic real into_decade(input real v, input real lo, input real hi);
        real w;
        w = v;
        while (w > hi)
            w = w / 10.0;
        while (w < lo)
            w = w * 10.0;
        return w;
    endfunction

    function automatic bit leading_digits_match(input real s, input real p, input int d);
        real hi;
        real lo;
        if (s == 0.0 || p == 0.0)
            return 1'b0;
        hi = $bitstoreal(ten_pow(d[3:0]));
        lo = $bitstoreal(ten_pow(d[3:0] - 4'd1));
        s = into_decade(s < 0.0 ? -s : s, lo, hi);
        p = into_decade(p < 0.0 ? -p : p, lo, hi);
        return $floor(s) == $floor(p);
    endfunction

    // Arctangent as the block works it out: reduce, sum the series, undo
    function automatic logic [63:0] atan_bits(input logic [63:0] bits, input logic [3:0] dig);
        real x;
        real y;
        real term;
        real prev;
        real den;
        real sq;
        real sqrt3;
        real mx;
        bit  neg;
        bit  recip;
        bit  shifted;
        int  d;
        int  n;
        d = (dig == 4'd0) ? 1 : int'(dig);
        if (bits[62:52] == 11'h7FF && bits[51:0] != 52'd0)
            return C_QNAN;
        if (bits[62:0] == 63'd0)
            return 64'd0;
        x = $bitstoreal(bits);
        mx = (x < 0.0) ? -x : x;
        if (mx > $bitstoreal(C_BIG_LIMIT) || mx < $bitstoreal(C_TINY_LIMIT))
            return C_PINF;
        sqrt3 = $bitstoreal(C_SQRT3);
        neg = x < 0.0;
        recip = 1'b0;
        shifted = 1'b0;
        x = mx;
        if (x > 1.0) begin
            x = 1.0 / x;
            recip = 1'b1;
        end
        if (x > (2.0 - sqrt3)) begin
            shifted = 1'b1;
            x = (sqrt3 * x - 1.0) / (sqrt3 + x);
        end
        y = x;
        if (x != 0.0) begin
            term = x;
            den = 3.0;
            sq = x * x;
            n = 0;
            do begin
                term = -term * sq;
                prev = y;
                y = y + term / den;
                den = den + 2.0;
                n++;
            end while (!leading_digits_match(y, prev, d) && n < 64);
        end
        if (shifted)
            y = y + $bitstoreal(C_SIXTH_PI);
        if (recip)
            y = $bitstoreal(C_HALF_PI) - y;
        if (neg)
            y = -y;
        return $realtobits(y);
    endfunction

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (atan_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result_bits);
                error_count++;
            end else begin
                if (o_result_bits !== atan_queue[0]) begin
                    $display("%0t: result_bits expected %h actual %h",
                             $time, atan_queue[0], o_result_bits);
                    error_count++;
                end
                void'(atan_queue.pop_front());
            end
        end
    end

    // Watchdog: count cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("arctangent_series_test: done, errors");
            $finish;
        end
    end

    // Send one item, hold start until taken, then idle for a random gap
    task automatic send_arg(input logic [63:0] bits);
        int gap;
        i_start <= 1'b1;
        i_arg_bits <= bits;
        do
            @(posedge i_clk);
        while (o_busy);
        atan_queue.push_back(atan_bits(bits, digits_shadow));
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain outstanding results so the block is idle
    task automatic drain;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (atan_queue.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_digits(input logic [3:0] value);
        drain();
        i_digits_we <= 1'b1;
        i_digits <= value;
        @(posedge i_clk);
        i_digits_we <= 1'b0;
        digits_shadow = value;
    endtask

    // Argument with a moderate exponent, the bulk of real traffic
    function automatic logic [63:0] ordinary_arg();
        logic [63:0] v;
        v = {$urandom, $urandom};
        v[62:52] = 11'(1023 - 40 + $urandom_range(0, 80));
        return v;
    endfunction

    function automatic logic [63:0] random_arg();
        int pick;
        logic [63:0] v;
        pick = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (pick < 8) begin
            v[62:52] = 11'h7FF;
        end else if (pick < 12) begin
            v[62:0] = 63'd0;
        end else if (pick < 16) begin
            v[62:52] = 11'd0;
        end else if (pick < 30) begin
            return v;
        end else begin
            v = ordinary_arg();
        end
        return v;
    endfunction

    // Zeros, NaNs, infinities and both range limits
    task automatic test_special_values;
        send_arg(64'h0000_0000_0000_0000);
        send_arg(64'h8000_0000_0000_0000);
        send_arg(64'h7FF8_0000_0000_0000);
        send_arg(64'hFFFF_FFFF_FFFF_FFFF);
        send_arg(64'h7FF0_0000_0000_0001);
        send_arg(64'h7FF0_0000_0000_0000);
        send_arg(64'hFFF0_0000_0000_0000);
        send_arg(64'h7FEF_FFFF_FFFF_FFFF);
        send_arg(C_BIG_LIMIT);
        send_arg(C_BIG_LIMIT + 64'd1);
        send_arg(C_TINY_LIMIT);
        send_arg(C_TINY_LIMIT - 64'd1);
        send_arg(64'h8000_0000_0000_0001);
        send_arg({1'b1, C_TINY_LIMIT[62:0]});
    endtask

    // Each reduction path: reciprocal, pi/6 shift, reduced argument zero
    task automatic test_reductions;
        send_arg(C_ONE);
        send_arg({1'b1, C_ONE[62:0]});
        send_arg(C_TWO_M_SQ3);
        send_arg(C_TWO_M_SQ3 + 64'd1);
        send_arg(64'h3FE2_79A7_4590_331C);
        send_arg(C_SQRT3);
        send_arg(64'h3F50_6240_0000_0000);
        send_arg(64'hC059_0000_0000_0000);
        send_arg(64'h4024_0000_0000_0000);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_arg(random_arg());
    endtask

    // Run the series at the digit extremes and a few in between
    task automatic test_digit_settings;
        logic [3:0] setting;
        write_digits(4'd1);
        test_random(60);
        write_digits(4'd15);
        test_random(60);
        write_digits(4'd0);
        test_random(50);
        repeat (5) begin
            setting = 4'($urandom_range(0, 15));
            write_digits(setting);
            test_random(50);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_arg_bits = 64'd0;
        i_digits_we = 1'b0;
        i_digits = 4'd0;
        error_count = 0;
        idle_cycles = 0;
        digits_shadow = 4'd8;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_values();
        test_reductions();
        test_random(25);
        test_digit_settings();
        drain();
        if (error_count == 0)
            $display("arctangent_series_test: done, clean");
        else
            $display("arctangent_series_test: done, errors");
        $finish;
    end

endmodule
